FILE: src/bprs_pkg.sv
// Shared types and constants for the byte pattern replace stream block.
package bprs_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int CFG_W       = 64;
	localparam int REG_IDX_W   = 3;
	localparam int HIT_W       = 31;

	localparam logic [HIT_W-1:0] HIT_MAX = 31'h7FFF_FFFF;

	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [MAX_PATTERN-1:0][7:0] bytes_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_MATCH_LO       = 3'd1,
		REG_MATCH_HI       = 3'd2,
		REG_REPL_LO        = 3'd3,
		REG_REPL_HI        = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_REPL,
		TAIL_STATUS
	} tail_t;

	// effective pattern setup, length already clamped to 1..MAX_PATTERN
	typedef struct packed {
		logic [CNT_W-1:0] len;
		bytes_t           match;
		bytes_t           repl;
	} cfg_t;

	// results of one input item: raw window bytes, then an optional tail
	typedef struct packed {
		bytes_t           raw;
		logic [CNT_W-1:0] raw_cnt;
		tail_t            tail;
		logic [CNT_W-1:0] total;
		logic [HIT_W-1:0] hits;
	} desc_t;

endpackage

FILE: src/bprs_window.sv
// Input register, pending window, hit counter and per-item match decision.
module bprs_window import bprs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    command,
	input  logic [7:0] data_byte,
	input  cfg_t    cfg,
	input  logic    load_ok,
	output logic    desc_load,
	output desc_t   desc
);

	logic             valid_s1;
	logic             cmd_s1;
	logic [7:0]       byte_s1;
	bytes_t           win_q;
	logic [IDX_W-1:0] cnt_q;
	logic [HIT_W-1:0] hits_q;

	logic             advance;
	bytes_t           comb_w;
	bytes_t           shifted;
	logic [CNT_W-1:0] fill;
	logic [CNT_W-1:0] excess;
	logic [CNT_W-1:0] len_m1;
	logic             hit;
	bytes_t           win_d;
	logic [IDX_W-1:0] cnt_d;
	logic [HIT_W-1:0] hits_d;

	assign advance   = valid_s1 & load_ok;
	assign in_ready  = ~valid_s1 | load_ok;
	assign desc_load = advance & (desc.total != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			byte_s1 <= data_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (IDX_W'(i) < cnt_q) begin
				comb_w[i] = win_q[i];
			end else if (IDX_W'(i) == cnt_q) begin
				comb_w[i] = byte_s1;
			end else begin
				comb_w[i] = 8'h00;
			end
		end
	end

	assign fill    = CNT_W'(cnt_q) + CNT_W'(1);
	assign excess  = (fill > cfg.len) ? (fill - cfg.len) : '0;
	assign shifted = comb_w >> {excess, 3'b000};
	assign len_m1  = cfg.len - CNT_W'(1);

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CNT_W'(i) < cfg.len) && (shifted[i] != cfg.match[i])) begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		desc.raw     = comb_w;
		desc.raw_cnt = '0;
		desc.tail    = TAIL_NONE;
		desc.total   = '0;
		desc.hits    = hits_q;
		win_d        = win_q;
		cnt_d        = cnt_q;
		hits_d       = hits_q;
		if (cmd_s1 == CMD_FLUSH) begin
			desc.raw     = win_q;
			desc.raw_cnt = CNT_W'(cnt_q);
			desc.tail    = TAIL_STATUS;
			desc.total   = fill;
			cnt_d        = '0;
			hits_d       = '0;
		end else if (fill < cfg.len) begin
			win_d = comb_w;
			cnt_d = fill[IDX_W-1:0];
		end else if (hit) begin
			desc.raw_cnt = excess;
			desc.tail    = TAIL_REPL;
			desc.total   = fill;
			cnt_d        = '0;
			hits_d       = (hits_q == HIT_MAX) ? hits_q : hits_q + HIT_W'(1);
		end else begin
			desc.raw_cnt = excess + CNT_W'(1);
			desc.total   = excess + CNT_W'(1);
			win_d        = shifted >> 8;
			cnt_d        = len_m1[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hits_q <= '0;
		end else if (advance) begin
			cnt_q  <= cnt_d;
			hits_q <= hits_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_d;
		end
	end

endmodule

FILE: src/bprs_emit.sv
// Result register and sequencer that sends the results of one item, one per transaction.
module bprs_emit import bprs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  desc_t            desc_in,
	input  bytes_t           repl,
	output logic             load_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             from_replacement,
	output logic             is_last,
	output logic [HIT_W-1:0] hit_count
);

	logic             busy_q;
	desc_t            desc_q;
	logic [IDX_W-1:0] idx_q;

	logic             fire;
	logic             last;
	logic             raw_sel;
	logic [IDX_W-1:0] ridx;

	assign fire    = busy_q & out_ready;
	assign last    = (CNT_W'(idx_q) + CNT_W'(1)) == desc_q.total;
	assign load_ok = ~busy_q | (fire & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire && last) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc_in;
		end
	end

	assign raw_sel   = CNT_W'(idx_q) < desc_q.raw_cnt;
	assign ridx      = idx_q - desc_q.raw_cnt[IDX_W-1:0];
	assign out_valid = busy_q;

	always_comb begin
		out_byte         = 8'h00;
		byte_valid       = 1'b0;
		from_replacement = 1'b0;
		is_last          = 1'b0;
		hit_count        = '0;
		if (raw_sel) begin
			out_byte   = desc_q.raw[idx_q];
			byte_valid = 1'b1;
		end else begin
			case (desc_q.tail)
				TAIL_REPL: begin
					out_byte         = repl[ridx];
					byte_valid       = 1'b1;
					from_replacement = 1'b1;
				end
				TAIL_STATUS: begin
					is_last   = 1'b1;
					hit_count = desc_q.hits;
				end
				default: begin
					out_byte = 8'h00;
				end
			endcase
		end
	end

endmodule

FILE: src/byte_pattern_replace_stream.sv
// Top level: configuration registers, window stage and result sequencer.
// Replaces each leftmost, non-overlapping occurrence of the match pattern in a byte stream
// with the equally long replacement pattern. A data byte is registered on acceptance and
// processed once the result sequencer can load its results into the result register (none
// while the window fills, one byte on a miss, the older bytes plus pattern_length replacement
// bytes on a hit). A flush sends the pending bytes and then one status transaction with the
// hit count, and clears window and count. The result sequencer sends one transaction per
// cycle while out_ready is high; with one result or fewer per byte and out_ready high the
// block takes one byte every cycle. The input register takes the next item while the
// sequencer still holds results. Write configuration only while the block is idle.
module byte_pattern_replace_stream import bprs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 from_replacement,
	output logic                 is_last,
	output logic [HIT_W-1:0]     hit_count,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [4:0]       len_q;
	logic [CFG_W-1:0] match_lo_q;
	logic [CFG_W-1:0] match_hi_q;
	logic [CFG_W-1:0] repl_lo_q;
	logic [CFG_W-1:0] repl_hi_q;

	cfg_t  cfg;
	desc_t desc;
	logic  desc_load;
	logic  load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= 5'd1;
			match_lo_q <= '0;
			match_hi_q <= '0;
			repl_lo_q  <= '0;
			repl_hi_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: len_q      <= cfg_data[4:0];
				REG_MATCH_LO:       match_lo_q <= cfg_data;
				REG_MATCH_HI:       match_hi_q <= cfg_data;
				REG_REPL_LO:        repl_lo_q  <= cfg_data;
				REG_REPL_HI:        repl_hi_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (len_q == 5'd0) begin
			cfg.len = CNT_W'(1);
		end else if (32'(len_q) > MAX_PATTERN) begin
			cfg.len = CNT_W'(MAX_PATTERN);
		end else begin
			cfg.len = CNT_W'(len_q);
		end
		cfg.match = bytes_t'({match_hi_q, match_lo_q});
		cfg.repl  = bytes_t'({repl_hi_q, repl_lo_q});
	end

	bprs_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.cfg       (cfg),
		.load_ok   (load_ok),
		.desc_load (desc_load),
		.desc      (desc)
	);

	bprs_emit u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (desc_load),
		.desc_in          (desc),
		.repl             (cfg.repl),
		.load_ok          (load_ok),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.byte_valid       (byte_valid),
		.from_replacement (from_replacement),
		.is_last          (is_last),
		.hit_count        (hit_count)
	);

	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result is pending");

	a_count_only_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> hit_count == '0)
		else $error("hit count on a stream byte");

	a_repl_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && from_replacement |-> byte_valid && !is_last)
		else $error("replacement flag on a status transaction");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
			&& $stable(from_replacement) && $stable(is_last) && $stable(hit_count))
		else $error("result changed while stalled");

endmodule
